// ===== sv/bpmf_pkg.sv =====
// Shared types, constants and register codes of the byte pattern match finder.
package bpmf_pkg;

   // Default sizes of the window and of the stream offset
   localparam int DEFAULT_MAX_PATTERN = 16;
   localparam int DEFAULT_OFFSET_BITS = 40;

   // Fixed field widths
   localparam int BYTE_W     = 8;
   localparam int RSP_OFF_W  = 40;
   localparam int COUNT_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int PLEN_W     = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Result queue depth; an item is taken only while two slots are free
   localparam int FIFO_DEPTH = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_MATCHES    = 2'd3;

   // Result kinds
   localparam logic KIND_MATCH  = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   typedef struct packed {
      logic                 result_kind;
      logic [RSP_OFF_W-1:0] match_offset;
      logic [COUNT_W-1:0]   match_total;
      logic                 run_end;
   } rslt_type;

   // Up to two results written into the queue in one cycle
   typedef struct packed {
      logic [1:0] count;
      rslt_type   first;
      rslt_type   second;
   } fifo_push_type;

   typedef struct packed {
      logic has_item;
      logic has_room;
   } fifo_stat_type;

endpackage

// ===== sv/bpmf_match_cell.sv =====
// One window cell: holds a stream byte (all but the last cell), compares its input byte with its pattern byte.
module bpmf_match_cell
   import bpmf_pkg::*;
#(
   parameter int MAX_PATTERN = DEFAULT_MAX_PATTERN,
   parameter int CELL_POS    = 0,
   parameter bit HOLD        = 1'b1,
   localparam int LEN_W      = $clog2(MAX_PATTERN + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                shift,
   input  logic                                clear,
   input  logic [BYTE_W-1:0]                   byte_in,
   output logic [BYTE_W-1:0]                   byte_out,
   input  logic [MAX_PATTERN-1:0][BYTE_W-1:0]  pattern,
   input  logic [LEN_W-1:0]                    used_len,
   output logic                                byte_ok
);

   logic [BYTE_W-1:0] pat_sel;

   // Pick pattern byte len-1-pos for this cell
   always_comb begin
      pat_sel = '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if (int'(used_len) - 1 - CELL_POS == k) begin
            pat_sel = pattern[k];
         end
      end
   end

   // Cells past the pattern length always agree
   assign byte_ok = (CELL_POS >= int'(used_len)) || (byte_in == pat_sel);

   // Hold the byte and pass it to the next cell on every shift; a shift with clear loads zero
   generate
      if (HOLD) begin : g_hold
         logic [BYTE_W-1:0] byte_ff;
         logic [BYTE_W-1:0] byte_next_in;

         always_comb begin
            byte_next_in = byte_ff;
            if (shift) begin
               byte_next_in = clear ? '0 : byte_in;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               byte_ff <= '0;
            end else begin
               byte_ff <= byte_next_in;
            end
         end

         assign byte_out = byte_ff;
      end else begin : g_last
         assign byte_out = '0;
      end
   endgenerate

endmodule

// ===== sv/bpmf_result_fifo.sv =====
// Small result queue that takes up to two results per cycle and hands out one.
module bpmf_result_fifo
   import bpmf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  fifo_push_type push,
   input  logic          pop,
   output rslt_type      head,
   output fifo_stat_type stat
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   rslt_type          slot_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pop_ok;

   assign pop_ok = pop && (count_ff != '0);

   // Advance pointers and fill level
   always_comb begin
      wr_in    = wr_ff + PTR_W'(push.count);
      rd_in    = rd_ff + PTR_W'(pop_ok);
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Write the first and second result into consecutive slots
   always_ff @(posedge clock) begin
      for (int i = 0; i < FIFO_DEPTH; i++) begin
         if (push.count != 2'd0 && PTR_W'(i) == wr_ff) begin
            slot_ff[i] <= push.first;
         end
         if (push.count == 2'd2 && PTR_W'(i) == PTR_W'(wr_ff + PTR_W'(1))) begin
            slot_ff[i] <= push.second;
         end
      end
   end

   assign head          = slot_ff[rd_ff];
   assign stat.has_item = (count_ff != '0);
   assign stat.has_room = (count_ff <= CNT_W'(FIFO_DEPTH - 2));

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("result queue overfilled");

   a_double_push: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2 && !pop_ok) |=> count_ff == $past(count_ff) + CNT_W'(2))
      else $error("double push lost a result");

   a_pop_moves_head: assert property (@(posedge clock) disable iff (reset)
      pop_ok |=> rd_ff == $past(rd_ff) + PTR_W'(1))
      else $error("read pointer did not advance on pop");
`endif

endmodule

// ===== sv/byte_pattern_match_finder_unit.sv =====
// A match or finish result is written into the result queue when its byte is accepted.
// Throughput: one byte per cycle while req_stall is low; the window compare over the cell row is combinational.
// A final byte with a match yields two results; the four-slot result queue absorbs them
// and holds off new bytes only while fewer than two slots are free.
// Reset (synchronous, active high) clears window, offset, count, halt flag and queue,
// and sets the registers to pattern zero, length one and no match limit.
module byte_pattern_match_finder_unit
   import bpmf_pkg::*;
#(
   parameter int MAX_PATTERN = DEFAULT_MAX_PATTERN,
   parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input items
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_data_byte,
   input  logic                   req_final_byte,
   // Result items
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_result_kind,
   output logic [RSP_OFF_W-1:0]   rsp_match_offset,
   output logic [COUNT_W-1:0]     rsp_match_total,
   output logic                   rsp_run_end,
   // Register writes
   input  logic                   csr_write_enable,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   // Registers
   logic [CSR_DATA_W-1:0] pat_low_ff;
   logic [CSR_DATA_W-1:0] pat_high_ff;
   logic [PLEN_W-1:0]     pat_len_ff;
   logic [COUNT_W-1:0]    max_ff;

   // Stream state
   logic [OFFSET_BITS-1:0] seen_ff, seen_in;
   logic [COUNT_W-1:0]     found_ff, found_in;
   logic                   halted_ff, halted_in;
   logic [LEN_W-1:0]       fill_ff, fill_in;

   logic                               accept;
   logic [LEN_W-1:0]                   used_len;
   logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_bytes;
   logic [MAX_PATTERN-1:0]             cell_ok;
   logic [MAX_PATTERN:0][BYTE_W-1:0]   chain;
   logic                               hit;
   logic [OFFSET_BITS-1:0]             start_off;
   rslt_type                           match_rslt;
   rslt_type                           finish_rslt;
   fifo_push_type                      push;
   fifo_stat_type                      stat;
   rslt_type                           head;

   assign req_stall = !stat.has_room;
   assign accept    = req_valid && !req_stall;

   // Write registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= PLEN_W'(1);
         max_ff      <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_PATTERN_LOW:    pat_low_ff  <= csr_write_data;
            REG_PATTERN_HIGH:   pat_high_ff <= csr_write_data;
            REG_PATTERN_LENGTH: pat_len_ff  <= csr_write_data[PLEN_W-1:0];
            REG_MAX_MATCHES:    max_ff      <= csr_write_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the length into one to the window size
   always_comb begin
      priority if (pat_len_ff == '0) begin
         used_len = LEN_W'(1);
      end else if (32'(pat_len_ff) > MAX_PATTERN) begin
         used_len = LEN_W'(MAX_PATTERN);
      end else begin
         used_len = LEN_W'(pat_len_ff);
      end
   end

   // Unpack pattern bytes; bytes past the sixteenth are zero
   generate
      for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
         if (k < 8) begin : g_lo
            assign pat_bytes[k] = pat_low_ff[8*k +: 8];
         end else if (k < 16) begin : g_hi
            assign pat_bytes[k] = pat_high_ff[8*(k-8) +: 8];
         end else begin : g_zero
            assign pat_bytes[k] = '0;
         end
      end
   endgenerate

   // Row of cells: the newest byte enters cell zero and moves one cell per item
   assign chain[0] = req_data_byte;

   generate
      for (genvar d = 0; d < MAX_PATTERN; d++) begin : g_cell
         bpmf_match_cell #(
            .MAX_PATTERN (MAX_PATTERN),
            .CELL_POS    (d),
            .HOLD        (d < MAX_PATTERN - 1)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (accept),
            .clear    (req_final_byte),
            .byte_in  (chain[d]),
            .byte_out (chain[d+1]),
            .pattern  (pat_bytes),
            .used_len (used_len),
            .byte_ok  (cell_ok[d])
         );
      end
   endgenerate

   // Match only once enough bytes of this stream have arrived
   assign hit = !halted_ff && (fill_ff >= used_len - LEN_W'(1)) && (&cell_ok);

   assign start_off = seen_ff - OFFSET_BITS'(used_len - LEN_W'(1));

   // Update stream state; the final byte starts a new stream
   always_comb begin
      found_in  = found_ff;
      halted_in = halted_ff;
      if (hit) begin
         if (found_ff != COUNT_MAX) begin
            found_in = found_ff + COUNT_W'(1);
         end
         if (max_ff != '0 && found_in >= max_ff) begin
            halted_in = 1'b1;
         end
      end
      seen_in = seen_ff + OFFSET_BITS'(1);
      fill_in = (fill_ff < LEN_W'(MAX_PATTERN)) ? fill_ff + LEN_W'(1) : fill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= '0;
         found_ff  <= '0;
         halted_ff <= 1'b0;
         fill_ff   <= '0;
      end else if (accept) begin
         if (req_final_byte) begin
            seen_ff   <= '0;
            found_ff  <= '0;
            halted_ff <= 1'b0;
            fill_ff   <= '0;
         end else begin
            seen_ff   <= seen_in;
            found_ff  <= found_in;
            halted_ff <= halted_in;
            fill_ff   <= fill_in;
         end
      end
   end

   // Build the results of this item
   always_comb begin
      match_rslt.result_kind  = KIND_MATCH;
      match_rslt.match_offset = RSP_OFF_W'(start_off);
      match_rslt.match_total  = found_in;
      match_rslt.run_end      = !req_final_byte;

      finish_rslt.result_kind  = KIND_FINISH;
      finish_rslt.match_offset = '0;
      finish_rslt.match_total  = found_in;
      finish_rslt.run_end      = 1'b1;

      push.count  = 2'd0;
      push.first  = match_rslt;
      push.second = finish_rslt;
      if (accept) begin
         priority if (hit && req_final_byte) begin
            push.count = 2'd2;
         end else if (hit) begin
            push.count = 2'd1;
         end else if (req_final_byte) begin
            push.count = 2'd1;
            push.first = finish_rslt;
         end else begin
            push.count = 2'd0;
         end
      end
   end

   bpmf_result_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (!rsp_stall),
      .head  (head),
      .stat  (stat)
   );

   assign rsp_valid        = stat.has_item;
   assign rsp_result_kind  = head.result_kind;
   assign rsp_match_offset = head.match_offset;
   assign rsp_match_total  = head.match_total;
   assign rsp_run_end      = head.run_end;

`ifndef NO_ASSERTIONS
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_final_byte) |=> (seen_ff == '0 && found_ff == '0 && !halted_ff
                                      && fill_ff == '0))
      else $error("stream state not cleared after final item");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LEN_W'(MAX_PATTERN))
      else $error("fill count beyond window size");

   a_halted_no_hit: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !hit)
      else $error("match reported after halt");
`endif

endmodule
